// ===== rtl/cxy_pkg.sv =====
// Shared types and constants of the CoreXY step and direction generator.
package cxy_pkg;

	localparam int INC_W = 12;
	localparam int LIM_W = 16;
	localparam int TGT_W = 16;

	localparam logic [INC_W-1:0] STEP_INC_RST = 12'd252;
	localparam logic [INC_W-1:0] SNAP_TOL_RST = 12'd246;
	localparam logic [LIM_W-1:0] X_LIMIT_RST  = 16'd131;
	localparam logic [LIM_W-1:0] Y_LIMIT_RST  = 16'd100;

	// last byte slot of a four-byte frame
	localparam logic [1:0] FRAME_LAST = 2'd3;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_HOME = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_STEP_INC = 2'd0,
		REG_SNAP_TOL = 2'd1,
		REG_X_LIMIT  = 2'd2,
		REG_Y_LIMIT  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] data_byte;
	} in_word_t;

	typedef struct packed {
		logic step_a;
		logic dir_a;
		logic step_b;
		logic dir_b;
		logic motor_awake;
		logic busy_led;
	} out_word_t;

	typedef struct packed {
		logic step_a;
		logic dir_a;
		logic step_b;
		logic dir_b;
	} motor_t;

endpackage

// ===== rtl/cxy_stream_if.sv =====
// Valid/ready word channel used for the command and result sides.
interface cxy_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/corexy_step_direction_generator.sv =====
// Top level of the CoreXY step and direction generator.
//
// Usage: words arrive on the cmd channel (valid/ready); each carries an
// operation and a data byte. A received byte (operation 0) joins a four-byte
// little-endian frame; the fourth byte loads new X and Y targets. A tick
// (operation 1) runs one CoreXY move: both motors take the sign of their
// error, step, and the Q(FRACTION_BITS) position advances by step_increment
// and snaps to its target within snap_tolerance. A home event (operation 2)
// clears targets and positions but leaves a partial frame in place.
// Every command word yields exactly one result word on the result channel,
// carrying the step pulses, direction pins, driver wake and busy indication.
// The command word passes the input register, then the result register, before
// result valid rises; a stall on the result side can hold it in between.
// Throughput: one word per cycle while result.ready stays high; the tick
// kinematics between the registers are a short chain of adds and compares.
// Registers: APB-style, word aligned, four registers at bytes 0, 4, 8, 12;
// write them only while the block is idle.
// Reset: arst_n clears both pipeline stages, the frame counter, targets,
// positions, held flags, and loads the register reset values.
// Stall: while result.ready is low the result word is held; the input
// register keeps one more word, after which cmd.ready drops.
module corexy_step_direction_generator #(
	parameter int FRACTION_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	cxy_stream_if.sink          cmd,
	cxy_stream_if.source        result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	localparam int POS_W = 17 + FRACTION_BITS;

	// configuration registers
	logic [cxy_pkg::INC_W-1:0] inc_q, tol_q;
	logic [cxy_pkg::LIM_W-1:0] xlim_q, ylim_q;

	// pipeline
	logic                 vld_s1;
	cxy_pkg::in_word_t    word_s1;
	logic                 out_vld_q;
	cxy_pkg::out_word_t   out_word_q;
	cxy_pkg::out_word_t   out_d;
	logic                 adv, fire;

	// block state
	logic [7:0]                frame_q [3];
	logic [1:0]                cnt_q;
	logic [cxy_pkg::TGT_W-1:0] tgt_x_q, tgt_y_q;
	logic [POS_W-1:0]          pos_x_q, pos_y_q;
	logic                      busy_q, dir_a_q, dir_b_q;
	logic                      busy_d, dir_a_d, dir_b_d;

	// kinematics
	logic             pending;
	cxy_pkg::motor_t  motor;
	logic [POS_W-1:0] pos_x_nxt, pos_y_nxt;

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q  <= cxy_pkg::STEP_INC_RST;
			tol_q  <= cxy_pkg::SNAP_TOL_RST;
			xlim_q <= cxy_pkg::X_LIMIT_RST;
			ylim_q <= cxy_pkg::Y_LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			case (cxy_pkg::reg_idx_t'(paddr[3:2]))
				cxy_pkg::REG_STEP_INC: inc_q  <= pwdata[cxy_pkg::INC_W-1:0];
				cxy_pkg::REG_SNAP_TOL: tol_q  <= pwdata[cxy_pkg::INC_W-1:0];
				cxy_pkg::REG_X_LIMIT:  xlim_q <= pwdata[cxy_pkg::LIM_W-1:0];
				cxy_pkg::REG_Y_LIMIT:  ylim_q <= pwdata[cxy_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cxy_pkg::reg_idx_t'(paddr[3:2]))
			cxy_pkg::REG_STEP_INC: prdata = 32'(inc_q);
			cxy_pkg::REG_SNAP_TOL: prdata = 32'(tol_q);
			cxy_pkg::REG_X_LIMIT:  prdata = 32'(xlim_q);
			cxy_pkg::REG_Y_LIMIT:  prdata = 32'(ylim_q);
			default:               prdata = '0;
		endcase
	end

	// ---------------------------------------------------------- handshake
	// Advance the pipeline whenever the result register is free or drains.
	assign adv        = !out_vld_q || result.ready;
	assign fire       = adv && vld_s1;
	assign cmd.ready  = !vld_s1 || adv;
	assign result.valid = out_vld_q;
	assign result.data  = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.ready) begin
				vld_s1 <= cmd.valid;
			end
			if (adv) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	// payload registers carry no reset
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			word_s1 <= cmd.data;
		end
		if (fire) begin
			out_word_q <= out_d;
		end
	end

	// --------------------------------------------------------- kinematics
	cxy_kin #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_kin (
		.pos_x     (pos_x_q),
		.pos_y     (pos_y_q),
		.tgt_x     (tgt_x_q),
		.tgt_y     (tgt_y_q),
		.inc       (inc_q),
		.tol       (tol_q),
		.lim_x     (xlim_q),
		.lim_y     (ylim_q),
		.pending   (pending),
		.motor     (motor),
		.pos_x_nxt (pos_x_nxt),
		.pos_y_nxt (pos_y_nxt)
	);

	// Build the result word and the next held flags. Only a tick touches
	// the flags: a pending move latches busy and both directions, an idle
	// tick drops busy and keeps the directions.
	always_comb begin
		busy_d  = busy_q;
		dir_a_d = dir_a_q;
		dir_b_d = dir_b_q;
		out_d   = '0;
		case (word_s1.operation)
			cxy_pkg::OP_TICK: begin
				if (pending) begin
					busy_d       = 1'b1;
					dir_a_d      = motor.dir_a;
					dir_b_d      = motor.dir_b;
					out_d.step_a = motor.step_a;
					out_d.step_b = motor.step_b;
				end else begin
					busy_d = 1'b0;
				end
			end
			default: ;
		endcase
		out_d.dir_a       = dir_a_d;
		out_d.dir_b       = dir_b_d;
		out_d.motor_awake = out_d.step_a | out_d.step_b;
		out_d.busy_led    = busy_d;
	end

	// -------------------------------------------------------------- state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			tgt_x_q <= '0;
			tgt_y_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			busy_q  <= 1'b0;
			dir_a_q <= 1'b0;
			dir_b_q <= 1'b0;
		end else if (fire) begin
			busy_q  <= busy_d;
			dir_a_q <= dir_a_d;
			dir_b_q <= dir_b_d;
			case (word_s1.operation)
				cxy_pkg::OP_BYTE: begin
					if (cnt_q != cxy_pkg::FRAME_LAST) begin
						cnt_q <= cnt_q + 2'd1;
					end else begin
						// fourth byte completes the frame: load both targets
						tgt_x_q <= {frame_q[1], frame_q[0]};
						tgt_y_q <= {word_s1.data_byte, frame_q[2]};
						cnt_q   <= '0;
					end
				end
				cxy_pkg::OP_TICK: begin
					if (pending) begin
						pos_x_q <= pos_x_nxt;
						pos_y_q <= pos_y_nxt;
					end
				end
				cxy_pkg::OP_HOME: begin
					// a partial frame stays partial
					tgt_x_q <= '0;
					tgt_y_q <= '0;
					pos_x_q <= '0;
					pos_y_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// frame byte store, always written before it is read within a frame
	always_ff @(posedge clk) begin
		if (fire && (word_s1.operation == cxy_pkg::OP_BYTE) &&
		    (cnt_q != cxy_pkg::FRAME_LAST)) begin
			frame_q[cnt_q] <= word_s1.data_byte;
		end
	end

endmodule

// ===== rtl/cxy_kin.sv =====
// CoreXY kinematics for one tick: motor signs, position move and snap.
module cxy_kin #(
	parameter int FRACTION_BITS = 12
) (
	input  logic [17+FRACTION_BITS-1:0] pos_x,
	input  logic [17+FRACTION_BITS-1:0] pos_y,
	input  logic [cxy_pkg::TGT_W-1:0]   tgt_x,
	input  logic [cxy_pkg::TGT_W-1:0]   tgt_y,
	input  logic [cxy_pkg::INC_W-1:0]   inc,
	input  logic [cxy_pkg::INC_W-1:0]   tol,
	input  logic [cxy_pkg::LIM_W-1:0]   lim_x,
	input  logic [cxy_pkg::LIM_W-1:0]   lim_y,
	output logic                        pending,
	output cxy_pkg::motor_t             motor,
	output logic [17+FRACTION_BITS-1:0] pos_x_nxt,
	output logic [17+FRACTION_BITS-1:0] pos_y_nxt
);
	localparam int POS_W = 17 + FRACTION_BITS;
	localparam int W     = POS_W + 3;

	logic signed [W-1:0] px, py, tx, ty, dx, dy, ea, eb;
	logic signed [W-1:0] incw, tolw, ta, tb, nx, ny, qx, qy, ex, ey;
	logic                snap_x, snap_y;

	always_comb begin
		px   = W'($signed(pos_x));
		py   = W'($signed(pos_y));
		tx   = $signed(W'({tgt_x, {FRACTION_BITS{1'b0}}}));
		ty   = $signed(W'({tgt_y, {FRACTION_BITS{1'b0}}}));
		incw = $signed(W'(inc));
		tolw = $signed(W'(tol));

		dx = tx - px;
		dy = ty - py;
		pending = ((dx != '0) && (tgt_x <= lim_x)) || ((dy != '0) && (tgt_y <= lim_y));

		// motor A follows dy - dx, motor B follows -(dx + dy)
		ea = dy - dx;
		eb = -dx - dy;

		ta = (ea == '0) ? '0 : (ea[W-1] ? -incw : incw);
		tb = (eb == '0) ? '0 : (eb[W-1] ? -incw : incw);

		motor.step_a = (ea != '0);
		motor.dir_a  = (ea != '0) && !ea[W-1];
		motor.step_b = (eb != '0);
		motor.dir_b  = (eb != '0) && !eb[W-1];

		nx = px - ta - tb;
		ny = py + ta - tb;

		// wrap to the position width before the snap compare
		qx = W'($signed(nx[POS_W-1:0]));
		qy = W'($signed(ny[POS_W-1:0]));

		ex = qx - tx;
		ey = qy - ty;
		snap_x = (ex > -tolw) && (ex < tolw);
		snap_y = (ey > -tolw) && (ey < tolw);

		pos_x_nxt = snap_x ? tx[POS_W-1:0] : qx[POS_W-1:0];
		pos_y_nxt = snap_y ? ty[POS_W-1:0] : qy[POS_W-1:0];
	end

endmodule

// ===== rtl/cxy_chk.sv =====
// Port-level checks for the CoreXY step and direction generator, with bind.
module cxy_chk (
	input logic          clk,
	input logic          arst_n,
	cxy_stream_if.sink   cmd,
	cxy_stream_if.source result
);

	// driver wake follows either step pulse
	a_awake: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.motor_awake ==
		                  (result.data.step_a | result.data.step_b)))
		else $error("motor_awake disagrees with the step pulses");

	// a motor only steps on a word that also reports busy
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.data.step_a || result.data.step_b))
		|-> result.data.busy_led)
		else $error("step pulse without busy");

	// a new result needs a command word accepted earlier, through the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.valid && cmd.ready, 2))
		else $error("result appeared without a matching command");

	// hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> (result.valid && $stable(result.data)))
		else $error("stalled result word changed");

endmodule

bind corexy_step_direction_generator cxy_chk u_cxy_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.cmd    (cmd),
	.result (result)
);

// ===== tb/tb_corexy_step_direction_generator.sv =====
// Self-checking testbench for the CoreXY step and direction generator.
`timescale 1ns / 100ps

module tb_corexy_step_direction_generator;

	localparam int FRAC        = 12;
	localparam int POS_W       = 17 + FRAC;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE      = 4;
	// spare operation code; the block must treat it as a word with no effect
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cxy_stream_if #(.T(cxy_pkg::in_word_t))  cmd_if ();
	cxy_stream_if #(.T(cxy_pkg::out_word_t)) res_if ();

	corexy_step_direction_generator #(.FRACTION_BITS(FRAC)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_if),
		.result  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the gantry: registers, frame assembly, targets, Q12 positions,
	// and the held flags (bit 0 busy, bit 1 dir_a, bit 2 dir_b).
	logic [cxy_pkg::INC_W-1:0] step_inc;
	logic [cxy_pkg::INC_W-1:0] snap_tol;
	logic [cxy_pkg::LIM_W-1:0] x_lim;
	logic [cxy_pkg::LIM_W-1:0] y_lim;
	logic [7:0]                frame_buf [3];
	logic [1:0]                frame_cnt;
	logic [cxy_pkg::TGT_W-1:0] tgt_x;
	logic [cxy_pkg::TGT_W-1:0] tgt_y;
	logic signed [POS_W-1:0]   pos_x;
	logic signed [POS_W-1:0]   pos_y;
	logic [2:0]                held;

	cxy_pkg::out_word_t pins_due [$];
	int        error_count;
	int        quiet_cycles;
	int        hold_request;
	bit        sender_idles;
	bit        receiver_stalls;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reduce a value to the signed position width, wrapping as the hardware does.
	function automatic longint wrap_pos(longint v);
		logic signed [POS_W-1:0] t;
		t = v[POS_W-1:0];
		return t;
	endfunction

	function automatic longint direction_of(longint v);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	// Snap is strict on both sides: a tolerance of zero never snaps.
	function automatic longint snap_to(longint p, longint t);
		longint diff;
		longint tol;
		diff = p - t;
		tol  = longint'(snap_tol);
		return (diff > -tol && diff < tol) ? t : p;
	endfunction

	// Advance the shadow by one command word and return the pins it should show.
	function automatic cxy_pkg::out_word_t gantry_response(cxy_pkg::in_word_t w);
		cxy_pkg::out_word_t r;
		longint    px, py, tx, ty, dx, dy, sa, sb, inc;
		bit        pending;
		r = '0;
		case (w.operation)
			cxy_pkg::OP_BYTE: begin
				if (frame_cnt != cxy_pkg::FRAME_LAST) begin
					frame_buf[frame_cnt] = w.data_byte;
					frame_cnt = frame_cnt + 2'd1;
				end else begin
					tgt_x = {frame_buf[1], frame_buf[0]};
					tgt_y = {w.data_byte, frame_buf[2]};
					frame_cnt = '0;
				end
			end
			cxy_pkg::OP_TICK: begin
				px = pos_x;
				py = pos_y;
				tx = longint'(tgt_x) << FRAC;
				ty = longint'(tgt_y) << FRAC;
				dx = tx - px;
				dy = ty - py;
				pending = (dx != 0 && tgt_x <= x_lim) || (dy != 0 && tgt_y <= y_lim);
				if (pending) begin
					sa  = direction_of(dy - dx);
					sb  = direction_of(-dx - dy);
					inc = longint'(step_inc);
					r.step_a = (sa != 0);
					r.step_b = (sb != 0);
					px = snap_to(wrap_pos(px - (sa + sb) * inc), tx);
					py = snap_to(wrap_pos(py + (sa - sb) * inc), ty);
					pos_x = px[POS_W-1:0];
					pos_y = py[POS_W-1:0];
					held = {(sb == 1), (sa == 1), 1'b1};
				end else begin
					// idle tick: directions stay, busy drops
					held[0] = 1'b0;
				end
			end
			cxy_pkg::OP_HOME: begin
				// partial frame survives a home event
				tgt_x = '0;
				tgt_y = '0;
				pos_x = '0;
				pos_y = '0;
			end
			default: ;
		endcase
		r.dir_a       = held[1];
		r.dir_b       = held[2];
		r.motor_awake = r.step_a | r.step_b;
		r.busy_led    = held[0];
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t ERROR %s", $time, what);
		error_count++;
	endtask

	// Offer one command word after a random gap; predict it once it is taken.
	task automatic send_word(cxy_pkg::op_t op, logic [7:0] b);
		cxy_pkg::in_word_t w;
		int       gap;
		w.operation = op;
		w.data_byte = b;
		gap = sender_idles ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.data  <= w;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		pins_due.push_back(gantry_response(w));
	endtask

	// Four bytes, little endian: X low, X high, Y low, Y high.
	task automatic send_frame(logic [15:0] x, logic [15:0] y);
		send_word(cxy_pkg::OP_BYTE, x[7:0]);
		send_word(cxy_pkg::OP_BYTE, x[15:8]);
		send_word(cxy_pkg::OP_BYTE, y[7:0]);
		send_word(cxy_pkg::OP_BYTE, y[15:8]);
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_word(cxy_pkg::OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	// Drop valid and hold until every predicted word has come back.
	task automatic wait_drained();
		cmd_if.valid <= 1'b0;
		while (pins_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_transfer(input bit is_write, input cxy_pkg::reg_idx_t idx,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write a register, mirror it in the shadow, and read it back.
	task automatic set_reg(cxy_pkg::reg_idx_t idx, logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] mask;
		apb_transfer(1'b1, idx, value, rd);
		case (idx)
			cxy_pkg::REG_STEP_INC: step_inc = value[cxy_pkg::INC_W-1:0];
			cxy_pkg::REG_SNAP_TOL: snap_tol = value[cxy_pkg::INC_W-1:0];
			cxy_pkg::REG_X_LIMIT:  x_lim    = value[cxy_pkg::LIM_W-1:0];
			cxy_pkg::REG_Y_LIMIT:  y_lim    = value[cxy_pkg::LIM_W-1:0];
			default: ;
		endcase
		mask = (idx == cxy_pkg::REG_STEP_INC || idx == cxy_pkg::REG_SNAP_TOL) ?
			((32'd1 << cxy_pkg::INC_W) - 1) : ((32'd1 << cxy_pkg::LIM_W) - 1);
		apb_transfer(1'b0, idx, 32'd0, rd);
		if ((rd & mask) !== (value & mask))
			report_mismatch($sformatf("register %s read %h, wrote %h",
				idx.name(), rd & mask, value & mask));
	endtask

	task automatic configure(int inc, int tol, int xl, int yl);
		wait_drained();
		set_reg(cxy_pkg::REG_STEP_INC, inc);
		set_reg(cxy_pkg::REG_SNAP_TOL, tol);
		set_reg(cxy_pkg::REG_X_LIMIT, xl);
		set_reg(cxy_pkg::REG_Y_LIMIT, yl);
	endtask

	// Mostly small targets near the origin so moves complete; some on and
	// just past the limit, a few anywhere.
	function automatic logic [15:0] pick_target(logic [15:0] lim);
		int cap;
		cap = (lim < 6) ? lim : 6;
		case ($urandom_range(0, 5))
			0, 1, 2: return 16'($urandom_range(0, cap));
			3:       return lim;
			4:       return lim + 16'd1;
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly whole frames followed by a run of ticks; the rest is homes
	// (often mid-frame), loose words of any operation, and drain pauses.
	task automatic run_traffic(int n_items);
		int sent, pick, k;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				send_frame(pick_target(x_lim), pick_target(y_lim));
				k = $urandom_range(1, 24);
				send_ticks(k);
				sent += 4 + k;
			end else if (pick < 16) begin
				k = $urandom_range(0, 3);
				repeat (k) send_word(cxy_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
				send_word(cxy_pkg::OP_HOME, 8'($urandom_range(0, 255)));
				sent += k + 1;
			end else if (pick < 19) begin
				send_word(cxy_pkg::op_t'($urandom_range(0, 3)),
					8'($urandom_range(0, 255)));
				sent++;
			end else begin
				wait_drained();
			end
		end
	endtask

	task automatic test_idle_after_reset();
		// nothing targeted yet: busy low, no pulses
		send_ticks(1);
		send_word(cxy_pkg::OP_HOME, 8'h00);
	endtask

	task automatic test_single_pixel_move();
		// one pixel in X: both motors step until the axis snaps, then idle
		send_frame(16'd1, 16'd0);
		send_ticks(9);
	endtask

	task automatic test_zero_sign_motor();
		// equal errors in X and Y leave motor A with no sign: no pulse, dir low
		send_word(cxy_pkg::OP_HOME, 8'hFF);
		send_frame(16'd1, 16'd1);
		send_ticks(2);
	endtask

	task automatic test_partial_frame_home();
		// home between halves of a frame, a spare opcode, targets past limits
		send_word(cxy_pkg::OP_BYTE, 8'hFF);
		send_word(cxy_pkg::OP_BYTE, 8'hFF);
		send_word(cxy_pkg::OP_HOME, 8'hFF);
		send_word(cxy_pkg::op_t'(OP_SPARE), 8'h55);
		send_word(cxy_pkg::OP_BYTE, 8'hFF);
		send_word(cxy_pkg::OP_BYTE, 8'hFF);
		send_word(cxy_pkg::OP_TICK, 8'hAA);
	endtask

	task automatic test_result_backpressure();
		// hold the result side for a long stretch while commands keep coming
		wait_drained();
		sender_idles    = 1'b0;
		receiver_stalls = 1'b0;
		hold_request    = 150;
		send_frame(16'd3, 16'd2);
		send_ticks(40);
		wait_drained();
		sender_idles    = 1'b1;
		receiver_stalls = 1'b1;
	endtask

	task automatic test_register_sweep();
		// large steps, wide snap, no limits; run without idling on either side
		configure(4095, 4095, 65535, 65535);
		sender_idles    = 1'b0;
		receiver_stalls = 1'b0;
		run_traffic(150);
		sender_idles    = 1'b1;
		receiver_stalls = 1'b1;
		// finest step, no snap, limits at zero
		configure(1, 0, 0, 0);
		run_traffic(150);
		// zero step: motors pulse, position moves only by snapping
		configure(0, $urandom_range(0, 4095), $urandom_range(0, 200), $urandom_range(0, 200));
		run_traffic(100);
		repeat (3) begin
			configure($urandom_range(1, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 300), $urandom_range(0, 300));
			run_traffic(100);
		end
	endtask

	// Compare each result word with the oldest prediction.
	always @(posedge clk) begin : check_pins
		cxy_pkg::out_word_t want;
		cxy_pkg::out_word_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = res_if.data;
			if (pins_due.size() == 0) begin
				report_mismatch($sformatf("result word %b with nothing expected", got));
			end else begin
				want = pins_due.pop_front();
				if (got.step_a !== want.step_a)
					report_mismatch($sformatf("step_a %b, want %b", got.step_a, want.step_a));
				if (got.dir_a !== want.dir_a)
					report_mismatch($sformatf("dir_a %b, want %b", got.dir_a, want.dir_a));
				if (got.step_b !== want.step_b)
					report_mismatch($sformatf("step_b %b, want %b", got.step_b, want.step_b));
				if (got.dir_b !== want.dir_b)
					report_mismatch($sformatf("dir_b %b, want %b", got.dir_b, want.dir_b));
				if (got.motor_awake !== want.motor_awake)
					report_mismatch($sformatf("motor_awake %b, want %b",
						got.motor_awake, want.motor_awake));
				if (got.busy_led !== want.busy_led)
					report_mismatch($sformatf("busy_led %b, want %b",
						got.busy_led, want.busy_led));
			end
		end
	end

	// Result side: stall for a random count before each word, or for a long
	// hold when one is requested; count the hold here, not in the sender.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request > 0)
				stall = hold_request;
			else
				stall = receiver_stalls ? $urandom_range(0, 11) : 0;
			hold_request = 0;
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (!res_if.valid) @(posedge clk);
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t ERROR watchdog: no word moved for %0d cycles", $time, quiet_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		// drive every input to a known value and hold reset
		arst_n       <= 1'b0;
		cmd_if.valid <= 1'b0;
		cmd_if.data  <= '0;
		res_if.ready <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		error_count     = 0;
		quiet_cycles    = 0;
		hold_request    = 0;
		sender_idles    = 1'b1;
		receiver_stalls = 1'b1;
		step_inc  = cxy_pkg::STEP_INC_RST;
		snap_tol  = cxy_pkg::SNAP_TOL_RST;
		x_lim     = cxy_pkg::X_LIMIT_RST;
		y_lim     = cxy_pkg::Y_LIMIT_RST;
		frame_buf = '{default: 8'h00};
		frame_cnt = '0;
		tgt_x     = '0;
		tgt_y     = '0;
		pos_x     = '0;
		pos_y     = '0;
		held      = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_after_reset();
		test_single_pixel_move();
		test_zero_sign_motor();
		test_partial_frame_home();
		// random traffic on the reset register values
		run_traffic(300);
		test_result_backpressure();
		test_register_sweep();

		wait_drained();
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
